/* src/hkrd_pkg.sv */
// Package for the key report differ: word types, key constants and the pad map.
package hkrd_pkg;

    // Key slots in one report; fixed by the report layout.
    localparam int KEY_SLOTS = 6;
    // Default depth of the held-key list.
    localparam int LIST_DEPTH_DEF = 8;

    localparam logic [7:0] MOD_FLAG   = 8'h80;
    localparam logic [7:0] MOD_SHIFT  = 8'h02;
    localparam logic [7:0] MOD_ALT    = 8'h04;
    localparam logic [7:0] CODE_SHIFT = MOD_FLAG | MOD_SHIFT;
    localparam logic [7:0] CODE_ALT   = MOD_FLAG | MOD_ALT;
    localparam logic [7:0] KEY_NONE   = 8'h00;

    localparam logic [4:0] PAD_NONE  = 5'd0;
    localparam logic [4:0] PAD_SHIFT = 5'd16;
    localparam logic [4:0] PAD_ALT   = 5'd21;
    localparam logic [4:0] PAD_MAX   = 5'd25;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_in_word;

    typedef struct packed {
        logic       event_valid;
        logic [7:0] key_code;
        logic [4:0] pad_pos;
        logic       pressed;
    } t_out_word;

    // Pad position of a key code, 0 when the code is not on the pad.
    function automatic logic [4:0] pad_index(input logic [7:0] code);
        logic [4:0] idx;
        case (code)
            8'h1E:      idx = 5'd1;
            8'h1F:      idx = 5'd2;
            8'h20:      idx = 5'd3;
            8'h21:      idx = 5'd4;
            8'h22:      idx = 5'd5;
            8'h2B:      idx = 5'd6;
            8'h14:      idx = 5'd7;
            8'h1A:      idx = 5'd8;
            8'h08:      idx = 5'd9;
            8'h15:      idx = 5'd10;
            8'h39:      idx = 5'd11;
            8'h04:      idx = 5'd12;
            8'h16:      idx = 5'd13;
            8'h07:      idx = 5'd14;
            8'h09:      idx = 5'd15;
            CODE_SHIFT: idx = PAD_SHIFT;
            8'h1D:      idx = 5'd17;
            8'h1B:      idx = 5'd18;
            8'h06:      idx = 5'd19;
            8'h2C:      idx = 5'd20;
            CODE_ALT:   idx = PAD_ALT;
            8'h50:      idx = 5'd22;
            8'h52:      idx = 5'd23;
            8'h4F:      idx = 5'd24;
            8'h51:      idx = 5'd25;
            default:    idx = PAD_NONE;
        endcase
        return idx;
    endfunction

endpackage

/* src/hkrd_diff.sv */
// Report compare logic: compacts key slots, finds press/release/modifier event, next state.
module hkrd_diff
    import hkrd_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    localparam int CNT_W = $clog2(LIST_DEPTH + 1)
) (
    input  t_in_word                     i_word,
    input  logic [LIST_DEPTH-1:0][7:0]   i_held_list,
    input  logic [CNT_W-1:0]             i_held_count,
    input  logic [7:0]                   i_held_mods,
    output t_out_word                    o_result,
    output logic [LIST_DEPTH-1:0][7:0]   o_held_list,
    output logic [CNT_W-1:0]             o_held_count,
    output logic [7:0]                   o_held_mods
);

    localparam int CMP_W = $clog2(LIST_DEPTH + KEY_SLOTS + 2);

    logic [KEY_SLOTS-1:0][7:0]  slots;
    logic [KEY_SLOTS-1:0][7:0]  fresh;
    logic [CMP_W-1:0]           cnt;
    logic [CMP_W-1:0]           prev;
    logic                       key_ok;
    logic                       is_rel;
    logic                       is_add;
    logic [LIST_DEPTH-1:0]      mismatch;
    logic [LIST_DEPTH-1:0]      at_or_after;
    logic [7:0]                 rel_code;
    logic [LIST_DEPTH-1:0][7:0] rel_list;
    logic [7:0]                 add_key;
    logic                       dup;
    logic [LIST_DEPTH-1:0][7:0] add_list;
    logic                       add_ev;
    logic [7:0]                 key_code;
    logic                       key_press;
    logic [7:0]                 mod_diff;

    assign slots[0] = i_word.key_slot_0;
    assign slots[1] = i_word.key_slot_1;
    assign slots[2] = i_word.key_slot_2;
    assign slots[3] = i_word.key_slot_3;
    assign slots[4] = i_word.key_slot_4;
    assign slots[5] = i_word.key_slot_5;

    // Compact nonzero slots in order.
    always_comb begin
        logic [CMP_W-1:0] pos [KEY_SLOTS];
        cnt = '0;
        for (int s = 0; s < KEY_SLOTS; s++) begin
            pos[s] = cnt;
            if (slots[s] != KEY_NONE) begin
                cnt = cnt + CMP_W'(1);
            end
        end
        for (int j = 0; j < KEY_SLOTS; j++) begin
            fresh[j] = KEY_NONE;
            for (int s = 0; s < KEY_SLOTS; s++) begin
                if (slots[s] != KEY_NONE && pos[s] == CMP_W'(j)) begin
                    fresh[j] = fresh[j] | slots[s];
                end
            end
        end
    end

    assign prev   = CMP_W'(i_held_count);
    assign key_ok = (cnt <= CMP_W'(LIST_DEPTH));
    assign is_rel = key_ok && (cnt + CMP_W'(1) == prev);
    assign is_add = key_ok && (cnt == prev + CMP_W'(1));

    // Release: first held entry that differs; slots at or past the new count never match.
    always_comb begin
        logic [7:0] fv;
        logic       seen;
        seen     = 1'b0;
        rel_code = KEY_NONE;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            fv = KEY_NONE;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (j == i) begin
                    fv = fresh[j];
                end
            end
            mismatch[i] = (CMP_W'(i) >= cnt) || (i_held_list[i] != fv);
            if (mismatch[i] && !seen) begin
                rel_code = i_held_list[i];
            end
            seen           = seen | mismatch[i];
            at_or_after[i] = seen;
        end
        rel_list = i_held_list;
        for (int j = 0; j < LIST_DEPTH - 1; j++) begin
            if (CMP_W'(j) < cnt && at_or_after[j]) begin
                rel_list[j] = i_held_list[j+1];
            end
        end
    end

    // Press: new key sits at the old count; ignore it if already held.
    always_comb begin
        add_key = KEY_NONE;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            if (prev == CMP_W'(j)) begin
                add_key = fresh[j];
            end
        end
        dup      = 1'b0;
        add_list = i_held_list;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            if (CMP_W'(i) < prev && i_held_list[i] == add_key) begin
                dup = 1'b1;
            end
            if (CMP_W'(i) == prev) begin
                add_list[i] = add_key;
            end
        end
    end

    assign add_ev   = is_add && !dup;
    assign mod_diff = i_held_mods ^ i_word.modifiers;

    always_comb begin
        o_held_list  = i_held_list;
        o_held_count = i_held_count;
        key_code     = KEY_NONE;
        key_press    = 1'b0;
        if (is_rel) begin
            o_held_list  = rel_list;
            o_held_count = CNT_W'(cnt);
            key_code     = rel_code;
        end else if (add_ev) begin
            o_held_list  = add_list;
            o_held_count = CNT_W'(cnt);
            key_code     = add_key;
            key_press    = 1'b1;
        end

        o_held_mods = i_held_mods;
        if (key_code == KEY_NONE) begin
            if (mod_diff == MOD_SHIFT) begin
                key_code    = CODE_SHIFT;
                key_press   = |(i_word.modifiers & MOD_SHIFT);
                o_held_mods = i_word.modifiers;
            end else if (mod_diff == MOD_ALT) begin
                key_code    = CODE_ALT;
                key_press   = |(i_word.modifiers & MOD_ALT);
                o_held_mods = i_word.modifiers;
            end else begin
                o_held_mods = '0;
            end
        end

        if (key_code != KEY_NONE) begin
            o_result.event_valid = 1'b1;
            o_result.key_code    = key_code;
            o_result.pad_pos     = pad_index(key_code);
            o_result.pressed     = key_press;
        end else begin
            o_result = '0;
        end
    end

endmodule

/* src/hid_key_report_differ_unit.sv */
// Top level of the keyboard report differ: input stage, held-key state, result register.
//
// Takes one keyboard report word (modifier byte and six key slots) per cycle and
// gives exactly one result word per report: a key press, a key release, a shift or
// alt change, or a word with event_valid low. Throughput is one report per clock
// while the result is not stalled; a report is held in the input register, which
// feeds the compare logic, and the result register holds its output. All compare
// work over the held list is a single pass of parallel compares over LIST_DEPTH
// entries, so the held-state update loop is combinational between its registers
// and consecutive reports see each other's effects. A stalled result holds the
// result register; the input register keeps taking words until it also fills,
// then o_in_stall rises. Reset clears the held list, count and modifiers.
module hid_key_report_differ_unit
    import hkrd_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // input stage
    logic                       r_in_valid;
    t_in_word                   r_in_word;
    // result stage
    logic                       r_out_valid;
    t_out_word                  r_out_word;
    // held key state
    logic [LIST_DEPTH-1:0][7:0] r_held_list;
    logic [CNT_W-1:0]           r_held_count;
    logic [7:0]                 r_held_mods;

    t_out_word                  n_out_word;
    logic [LIST_DEPTH-1:0][7:0] n_held_list;
    logic [CNT_W-1:0]           n_held_count;
    logic [7:0]                 n_held_mods;

    logic in_take;
    logic advance;

    // The input word moves on whenever the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    hkrd_diff #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_diff (
        .i_word       (r_in_word),
        .i_held_list  (r_held_list),
        .i_held_count (r_held_count),
        .i_held_mods  (r_held_mods),
        .o_result     (n_out_word),
        .o_held_list  (n_held_list),
        .o_held_count (n_held_count),
        .o_held_mods  (n_held_mods)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_held_list  <= '0;
            r_held_count <= '0;
            r_held_mods  <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // state commits only when the word's result is captured
            if (advance) begin
                r_held_list  <= n_held_list;
                r_held_count <= n_held_count;
                r_held_mods  <= n_held_mods;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* src/hkrd_checker.sv */
// Port-level checker for the key report differ, bound to the top level.
module hkrd_checker
    import hkrd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a word without an event carries all zero fields
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.event_valid |->
            o_out_word.key_code == KEY_NONE && o_out_word.pad_pos == PAD_NONE
            && !o_out_word.pressed)
        else $error("idle result word has nonzero fields");

    // an event always names a key, and its pad index is no higher than PAD_MAX
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_valid |->
            o_out_word.key_code != KEY_NONE && o_out_word.pad_pos <= PAD_MAX)
        else $error("event with empty key code or bad pad index");

    // modifier events carry one of the two modifier pad positions
    a_mod_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.key_code == CODE_SHIFT
            || o_out_word.key_code == CODE_ALT) |->
            (o_out_word.pad_pos == PAD_SHIFT || o_out_word.pad_pos == PAD_ALT))
        else $error("modifier event with wrong pad index");

endmodule

bind hid_key_report_differ_unit hkrd_checker u_hkrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

/* sim/testbench.sv */
// Self-checking testbench for the keyboard report differ: random-stall driver, monitor, predictor.
//
// Reports are queued by the stimulus block and driven one word at a time. Each word the
// block accepts is run through a local model of the differ, and the expected event word
// is queued. The monitor compares each accepted result word, field by field, with the
// oldest expected one. The sender and the receiver stall at random in the first two of three phases.
// A separate counter makes the receiver hold off for long stretches, so the block
// fills up and stalls its input.
module testbench
    import hkrd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 120;   // length of one long receiver hold-off
    localparam int HOLD_PERIOD = 1500;  // a hold-off starts once per this many cycles
    localparam int DRAIN_WAIT  = 8;     // two-stage pipe, plus margin
    localparam int MAX_SHOWN   = 10;

    // Key codes on the pad, in pad order: the first is pad 1, the last is pad 25.
    localparam logic [8*25-1:0] PAD_CODES = {
        8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15,
        8'h39, 8'h04, 8'h16, 8'h07, 8'h09, CODE_SHIFT, 8'h1D, 8'h1B, 8'h06, 8'h2C,
        CODE_ALT, 8'h50, 8'h52, 8'h4F, 8'h51
    };

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    hid_key_report_differ_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Reports waiting to be driven, and event words waiting to come out.
    t_in_word  reports_q [$];
    t_out_word events_due [$];

    // Stall rates in percent; changed only at the falling edge by the stimulus block.
    int send_idle_pct  = 25;
    int recv_stall_pct = 60;

    // Model state: ordered list of held keys, its length, and the held modifier byte.
    logic [7:0] held_keys [LIST_DEPTH_DEF];
    logic [3:0] held_num  = '0;
    logic [7:0] held_mods = '0;

    // Stimulus generator view: the keys physically down, in report order.
    logic [7:0] keys_down [$];
    logic [7:0] gen_mods = '0;

    int errors    = 0;
    int cycles    = 0;
    int hold_left = 0;
    int hold_clk  = 0;
    int n_accepted, n_checked, n_press, n_release, n_quiet, n_in_stalled, n_holds;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- model
    function automatic logic [4:0] pad_of(input logic [7:0] code);
        logic [4:0] pad;
        pad = PAD_NONE;
        for (int p = 0; p < 25; p++) begin
            if (PAD_CODES[8*(24-p) +: 8] == code) begin
                pad = 5'(p + 1);
            end
        end
        return pad;
    endfunction

    // Works out the event word for one report and updates the held state.
    function automatic t_out_word diff_report(input t_in_word w);
        logic [7:0] slots [KEY_SLOTS];
        logic [7:0] fresh [KEY_SLOTS];
        logic [7:0] code;
        logic [7:0] mod_diff;
        logic       press;
        logic       dup;
        int         n;
        int         i;
        t_out_word  r;
        slots = '{w.key_slot_0, w.key_slot_1, w.key_slot_2,
                  w.key_slot_3, w.key_slot_4, w.key_slot_5};
        n     = 0;
        code  = KEY_NONE;
        press = 1'b0;
        for (i = 0; i < KEY_SLOTS; i++) begin
            fresh[i] = KEY_NONE;
        end
        for (i = 0; i < KEY_SLOTS; i++) begin
            if (slots[i] != KEY_NONE) begin
                fresh[n] = slots[i];
                n++;
            end
        end
        if (n <= LIST_DEPTH_DEF && held_num <= LIST_DEPTH_DEF) begin
            if (n + 1 == held_num) begin
                // release: first held entry that differs, or the first one past the new count
                i = 0;
                while (i < held_num && i < n && held_keys[i] == fresh[i]) begin
                    i++;
                end
                code = held_keys[i];
                while (i < n) begin
                    held_keys[i] = held_keys[i+1];
                    i++;
                end
                held_num = 4'(n);
            end else if (n == held_num + 1) begin
                dup = 1'b0;
                for (i = 0; i < held_num; i++) begin
                    if (held_keys[i] == fresh[held_num]) begin
                        dup = 1'b1;
                    end
                end
                if (!dup) begin
                    code = fresh[held_num];
                    held_keys[held_num] = code;
                    held_num = 4'(n);
                    press = 1'b1;
                end
            end
        end
        // modifiers only count when no key changed
        if (code == KEY_NONE) begin
            mod_diff = held_mods ^ w.modifiers;
            if (mod_diff == MOD_SHIFT) begin
                code      = CODE_SHIFT;
                press     = (w.modifiers & MOD_SHIFT) != 0;
                held_mods = w.modifiers;
            end else if (mod_diff == MOD_ALT) begin
                code      = CODE_ALT;
                press     = (w.modifiers & MOD_ALT) != 0;
                held_mods = w.modifiers;
            end else begin
                held_mods = '0;
            end
        end
        r.event_valid = (code != KEY_NONE);
        r.key_code    = code;
        r.pad_pos     = pad_of(code);
        r.pressed     = (code != KEY_NONE) ? press : 1'b0;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    task automatic push_report(input logic [7:0] m, input logic [7:0] k0, input logic [7:0] k1,
                               input logic [7:0] k2, input logic [7:0] k3,
                               input logic [7:0] k4, input logic [7:0] k5);
        t_in_word w;
        w = '{m, k0, k1, k2, k3, k4, k5};
        reports_q.push_back(w);
    endtask

    function automatic bit is_down(input logic [7:0] k);
        bit found;
        found = 1'b0;
        foreach (keys_down[j]) begin
            if (keys_down[j] == k) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // A key not currently down: mostly pad keys, the rest any nonzero code.
    function automatic logic [7:0] fresh_code();
        logic [7:0] k;
        int         p;
        do begin
            p = $urandom_range(24);
            if ($urandom_range(9) < 7) begin
                k = PAD_CODES[8*p +: 8];
            end else begin
                k = 8'($urandom_range(255, 1));
            end
        end while (is_down(k));
        return k;
    endfunction

    // Spread the keys that are down over the slots, in order, with random empty slots.
    task automatic send_keys();
        logic [7:0] s [KEY_SLOTS];
        int         pos;
        int         left;
        pos = 0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            left = keys_down.size() - pos;
            if (left != 0 && (left == KEY_SLOTS - j || $urandom_range(9) < 7)) begin
                s[j] = keys_down[pos];
                pos++;
            end else begin
                s[j] = KEY_NONE;
            end
        end
        push_report(gen_mods, s[0], s[1], s[2], s[3], s[4], s[5]);
    endtask

    // One random keyboard action; mostly single presses, releases and modifier taps.
    task automatic random_action();
        int         pick;
        logic [7:0] k;
        pick = $urandom_range(99);
        if (pick < 30 && keys_down.size() == KEY_SLOTS) begin
            pick = 40;
        end
        if (pick >= 30 && pick < 55 && keys_down.size() == 0) begin
            pick = 10;
        end
        if (pick < 30) begin
            k = fresh_code();
            // now and then the new key lands mid-report, out of order
            if ($urandom_range(9) == 0) begin
                keys_down.insert($urandom_range(keys_down.size()), k);
            end else begin
                keys_down.push_back(k);
            end
            if ($urandom_range(9) == 0) begin
                gen_mods ^= MOD_SHIFT;
            end
        end else if (pick < 55) begin
            keys_down.delete($urandom_range(keys_down.size() - 1));
            if ($urandom_range(9) == 0) begin
                gen_mods ^= MOD_ALT;
            end
        end else if (pick < 70) begin
            gen_mods ^= $urandom_range(1) ? MOD_SHIFT : MOD_ALT;
        end else if (pick < 75) begin
            gen_mods = 8'($urandom_range(255));
        end else if (pick < 80) begin
            // repeat a key that is already down
            if (keys_down.size() != 0 && keys_down.size() < KEY_SLOTS) begin
                keys_down.push_back(keys_down[$urandom_range(keys_down.size() - 1)]);
            end
        end else if (pick < 85) begin
            // two keys at once
            if (keys_down.size() <= KEY_SLOTS - 2) begin
                keys_down.push_back(fresh_code());
                keys_down.push_back(fresh_code());
            end else begin
                keys_down.delete($urandom_range(keys_down.size() - 1));
                keys_down.delete($urandom_range(keys_down.size() - 1));
            end
        end else if (pick < 90) begin
            if (keys_down.size() != 0) begin
                keys_down[$urandom_range(keys_down.size() - 1)] = fresh_code();
            end
        end else if (pick < 93) begin
            // same report again
        end else if (pick < 96) begin
            keys_down.delete();
        end else begin
            // noise: any content, duplicates allowed
            keys_down.delete();
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if ($urandom_range(1)) begin
                    keys_down.push_back(8'($urandom_range(255, 1)));
                end
            end
            gen_mods = 8'($urandom_range(255));
        end
        send_keys();
    endtask

    task automatic wait_queue_empty();
        while (reports_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- stimulus and end
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: state starts empty.
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // nothing, mods unchanged
        push_report(8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // press
        push_report(8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF); // press, unmapped
        push_report(8'h00, 8'h1E, 8'hFF, 8'h1E, 8'h00, 8'h00, 8'h00); // duplicate press
        push_report(8'h00, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h01, 8'h00); // same count, swapped
        push_report(8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00); // release of the first
        push_report(8'h00, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // press, last pad key
        push_report(8'h00, 8'hFF, 8'h51, 8'h82, 8'h00, 8'h00, 8'h00); // press of code 0x82
        push_report(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h51, 8'h00); // release past new count
        push_report(8'h02, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // shift down
        push_report(8'h06, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // alt down
        push_report(8'h04, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // shift up
        push_report(8'hFF, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // many bits: clear
        push_report(8'h00, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // unchanged: no event
        push_report(8'h04, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // alt down
        push_report(8'h00, 8'hFF, 8'h51, 8'h00, 8'h00, 8'h00, 8'h00); // alt up
        push_report(8'h00, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h00, 8'h00); // two at once
        push_report(8'h01, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h7F, 8'h55); // other bit, too many
        push_report(8'h00, 8'hFF, 8'h51, 8'h01, 8'h00, 8'h00, 8'h00); // press
        push_report(8'h00, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h00, 8'h00); // press
        push_report(8'h00, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h7F, 8'h00); // press
        push_report(8'h02, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h7F, 8'hAA); // key wins over shift
        push_report(8'h02, 8'hFF, 8'h51, 8'h01, 8'h80, 8'h7F, 8'hAA); // then shift down
        push_report(8'h00, 8'hFF, 8'h51, 8'h01, 8'h7F, 8'hAA, 8'h00); // release mid-list
        push_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // drop all: no key event, shift up

        // Random phases: sender idles less than receiver, then the reverse, then no idling.
        repeat (650) random_action();
        wait_queue_empty();
        send_idle_pct  = 60;
        recv_stall_pct = 25;
        repeat (650) random_action();
        wait_queue_empty();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (600) random_action();

        while (reports_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (events_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        errors += events_due.size();

        $display("summary: %0d reports, %0d checked: %0d presses, %0d releases, %0d quiet",
                 n_accepted, n_checked, n_press, n_release, n_quiet);
        $display("summary: %0d long hold-offs, input stalled on %0d cycles, %0d errors",
                 n_holds, n_in_stalled, errors);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver
    // A new word goes out only when the current one is gone; idling never looks at stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (reports_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= reports_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Every accepted report updates the model and queues its event word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LIST_DEPTH_DEF; j++) begin
                held_keys[j] = '0;
            end
            held_num  = '0;
            held_mods = '0;
        end else if (i_in_valid) begin
            if (o_in_stall) begin
                n_in_stalled++;
            end else begin
                events_due.push_back(diff_report(i_in_word));
                n_accepted++;
            end
        end
    end

    // Long receiver hold-off, counted here so it stays apart from the random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_clk  <= 0;
        end else begin
            hold_clk <= hold_clk + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (hold_clk % HOLD_PERIOD == HOLD_PERIOD / 2) begin
                hold_left <= HOLD_CYCLES;
                n_holds++;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_out_word want;
        i_out_stall <= i_rst_n && (hold_left != 0 || $urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (events_due.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("unexpected word: valid=%0b code=%02h index=%0d pressed=%0b",
                             o_out_word.event_valid, o_out_word.key_code,
                             o_out_word.pad_pos, o_out_word.pressed);
                end
            end else begin
                want = events_due.pop_front();
                n_checked++;
                if (!want.event_valid) begin
                    n_quiet++;
                end else if (want.pressed) begin
                    n_press++;
                end else begin
                    n_release++;
                end
                if (o_out_word.event_valid !== want.event_valid ||
                    o_out_word.key_code    !== want.key_code    ||
                    o_out_word.pad_pos     !== want.pad_pos     ||
                    o_out_word.pressed     !== want.pressed) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("word %0d: expected valid=%0b code=%02h index=%0d pressed=%0b",
                                 n_checked, want.event_valid, want.key_code,
                                 want.pad_pos, want.pressed,
                                 ", got valid=%0b code=%02h index=%0d pressed=%0b",
                                 o_out_word.event_valid, o_out_word.key_code,
                                 o_out_word.pad_pos, o_out_word.pressed);
                    end
                end
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, events_due.size());
            $display("testbench: errors");
            $finish;
        end
    end

endmodule

/* filelist.f */
src/hkrd_pkg.sv
src/hkrd_diff.sv
src/hid_key_report_differ_unit.sv
src/hkrd_checker.sv
sim/testbench.sv
